// ===== rtl/level_meter_ballistics_macros.svh =====
// assertion macros for the level meter ballistics checker
`ifndef LEVEL_METER_BALLISTICS_MACROS_SVH
`define LEVEL_METER_BALLISTICS_MACROS_SVH

// same-cycle implication, checked on the rising clock outside reset
`define LMB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock outside reset
`define LMB_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lmb_pkg.sv =====
// shared types and constants for the level meter ballistics block
package lmb_pkg;

   localparam int CHANNELS   = 4;
   localparam int CH_W       = 2;
   localparam int LVL_W      = 16;
   localparam int COEF_W     = 16;
   localparam int HOLD_W     = 8;
   localparam int DB_W       = 16;
   localparam int POS_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MAG_W      = 20;
   localparam int K_W        = 19;
   localparam int PROD_W     = MAG_W + K_W;

   // 20*log10(2) in Q.16
   localparam logic [K_W-1:0] DB_PER_LOG2 = 19'd394566;

   localparam logic [COEF_W-1:0]     LEVEL_COEF_RST = 16'd5243;
   localparam logic [COEF_W-1:0]     PEAK_COEF_RST  = 16'd2150;
   localparam logic [HOLD_W-1:0]     HOLD_RST       = 8'd30;
   localparam logic [LVL_W-1:0]      FLOOR_LVL_RST  = 16'd33;
   localparam logic signed [DB_W-1:0] FLOOR_DB_RST  = -16'sd15360;

   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_COEF = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_COEF  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_LVL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_DB   = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LVL,
      ST_LVL_SUB,
      ST_LDB_LOG,
      ST_LDB_MUL,
      ST_LDB_RND,
      ST_PEAK,
      ST_PK_SUB,
      ST_PDB_LOG,
      ST_PDB_MUL,
      ST_PDB_RND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } log_type;

endpackage

// ===== rtl/level_meter_ballistics.sv =====
// level meter ballistics top level: sequencer, channel state and csr bank
// takes one transaction at a time (req_ready only in idle) and uses one shared
// multiplier for level release, level dB, peak release and peak dB
// reset: synchronous, clears channel state, loads csr defaults, peak dB to floor
module level_meter_ballistics (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lmb_pkg::CH_W-1:0]            req_channel,
   input  logic [lmb_pkg::LVL_W-1:0]           req_level,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lmb_pkg::CH_W-1:0]            rsp_channel_out,
   output logic signed [lmb_pkg::DB_W-1:0]     rsp_level_db,
   output logic signed [lmb_pkg::DB_W-1:0]     rsp_peak_db,
   output logic                                rsp_peak_holding,
   input  logic                                csr_wr_en,
   input  logic [lmb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lmb_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import lmb_pkg::*;

   state_type state_ff, state_in;

   logic [COEF_W-1:0]      lvl_coef_ff, lvl_coef_in;
   logic [COEF_W-1:0]      pk_coef_ff, pk_coef_in;
   logic [HOLD_W-1:0]      hold_cfg_ff, hold_cfg_in;
   logic [LVL_W-1:0]       floor_lvl_ff, floor_lvl_in;
   logic signed [DB_W-1:0] floor_db_ff, floor_db_in;

   logic [LVL_W-1:0]       smooth_ff [CHANNELS];
   logic [LVL_W-1:0]       smooth_in [CHANNELS];
   logic [LVL_W-1:0]       peak_ff [CHANNELS];
   logic [LVL_W-1:0]       peak_in [CHANNELS];
   logic signed [DB_W-1:0] pkdb_ff [CHANNELS];
   logic signed [DB_W-1:0] pkdb_in [CHANNELS];
   logic [HOLD_W-1:0]      holdc_ff [CHANNELS];
   logic [HOLD_W-1:0]      holdc_in [CHANNELS];

   logic [CH_W-1:0]        ch_ff, ch_in;
   logic [LVL_W-1:0]       lvl_ff, lvl_in;
   logic [LVL_W-1:0]       cur_ff, cur_in;
   logic [LVL_W-1:0]       pk_ff, pk_in;
   logic [HOLD_W-1:0]      hold_ff, hold_in;
   logic signed [DB_W-1:0] ldb_ff, ldb_in;
   logic signed [DB_W-1:0] pdb_ff, pdb_in;
   logic [MAG_W-1:0]       mag_ff, mag_in;
   logic                   neg_ff, neg_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]        rsp_ch_ff, rsp_ch_in;
   logic signed [DB_W-1:0] rsp_ldb_ff, rsp_ldb_in;
   logic signed [DB_W-1:0] rsp_pdb_ff, rsp_pdb_in;
   logic                   rsp_hold_ff, rsp_hold_in;

   logic [MAG_W-1:0]       mul_a;
   logic [K_W-1:0]         mul_b;
   logic [PROD_W-1:0]      mul_prod;
   logic [PROD_W:0]        rel_sum;
   logic [PROD_W:0]        db_sum;
   logic [LVL_W-1:0]       rel_step;
   logic [DB_W-1:0]        db_mag;
   logic signed [DB_W-1:0] db_val;
   logic [LVL_W-1:0]       conv_gain;
   logic                   conv_floor;
   log_type                log_res;
   logic                   ch_ok;
   logic                   attack;
   logic                   peak_take;
   logic                   decay_ok;
   logic                   out_free;

   lmb_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   lmb_log2 u_log2 (
      .gain (conv_gain),
      .res  (log_res)
   );

   // shared decode
   always_comb begin
      ch_ok      = int'(req_channel) < CHANNELS;
      attack     = lvl_ff > cur_ff;
      peak_take  = cur_ff > pk_ff;
      decay_ok   = !peak_take && (hold_ff == '0) && (pdb_ff > floor_db_ff);
      out_free   = !rsp_valid_ff || rsp_ready;
      conv_gain  = (state_ff == ST_PDB_LOG) ? pk_ff : cur_ff;
      conv_floor = (conv_gain <= floor_lvl_ff) || (conv_gain == '0);
      rel_sum    = {1'b0, mul_prod} + (PROD_W + 1)'(32768);
      rel_step   = rel_sum[LVL_W+15:16];
      db_sum     = {1'b0, mul_prod} + (PROD_W + 1)'(24'h800000);
      db_mag     = db_sum[DB_W+23:24];
      db_val     = neg_ff ? -$signed(db_mag) : $signed(db_mag);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && ch_ok) begin
               state_in = ST_LVL;
            end
         end
         ST_LVL:     state_in = attack ? ST_LDB_LOG : ST_LVL_SUB;
         ST_LVL_SUB: state_in = ST_LDB_LOG;
         ST_LDB_LOG: state_in = conv_floor ? ST_PEAK : ST_LDB_MUL;
         ST_LDB_MUL: state_in = ST_LDB_RND;
         ST_LDB_RND: state_in = ST_PEAK;
         ST_PEAK:    state_in = decay_ok ? ST_PK_SUB : ST_DONE;
         ST_PK_SUB:  state_in = ST_PDB_LOG;
         ST_PDB_LOG: state_in = conv_floor ? ST_DONE : ST_PDB_MUL;
         ST_PDB_MUL: state_in = ST_PDB_RND;
         ST_PDB_RND: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and multiplier operands
   always_comb begin
      req_ready = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_LVL: begin
            mul_a = MAG_W'(cur_ff - lvl_ff);
            mul_b = K_W'(lvl_coef_ff);
         end
         ST_PEAK: begin
            mul_a = MAG_W'(pk_ff - cur_ff);
            mul_b = K_W'(pk_coef_ff);
         end
         ST_LDB_MUL, ST_PDB_MUL: begin
            mul_a = mag_ff;
            mul_b = DB_PER_LOG2;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath and state updates
   always_comb begin
      lvl_coef_in  = lvl_coef_ff;
      pk_coef_in   = pk_coef_ff;
      hold_cfg_in  = hold_cfg_ff;
      floor_lvl_in = floor_lvl_ff;
      floor_db_in  = floor_db_ff;
      smooth_in    = smooth_ff;
      peak_in      = peak_ff;
      pkdb_in      = pkdb_ff;
      holdc_in     = holdc_ff;
      ch_in        = ch_ff;
      lvl_in       = lvl_ff;
      cur_in       = cur_ff;
      pk_in        = pk_ff;
      hold_in      = hold_ff;
      ldb_in       = ldb_ff;
      pdb_in       = pdb_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_ldb_in   = rsp_ldb_ff;
      rsp_pdb_in   = rsp_pdb_ff;
      rsp_hold_in  = rsp_hold_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEVEL_COEF: lvl_coef_in  = csr_wdata;
            CSR_PEAK_COEF:  pk_coef_in   = csr_wdata;
            CSR_HOLD:       hold_cfg_in  = csr_wdata[HOLD_W-1:0];
            CSR_FLOOR_LVL:  floor_lvl_in = csr_wdata;
            CSR_FLOOR_DB:   floor_db_in  = $signed(csr_wdata);
            default:        floor_db_in  = floor_db_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            ch_in   = req_channel;
            lvl_in  = req_level;
            cur_in  = smooth_ff[req_channel];
            pk_in   = peak_ff[req_channel];
            hold_in = holdc_ff[req_channel];
            pdb_in  = pkdb_ff[req_channel];
         end
         ST_LVL: begin
            if (attack) begin
               cur_in = lvl_ff;
            end
         end
         ST_LVL_SUB: cur_in = cur_ff - rel_step;
         ST_LDB_LOG: begin
            ldb_in = floor_db_ff;
            mag_in = log_res.mag;
            neg_in = log_res.neg;
         end
         ST_LDB_RND: ldb_in = db_val;
         ST_PEAK: begin
            priority if (peak_take) begin
               pk_in   = cur_ff;
               pdb_in  = ldb_ff;
               hold_in = hold_cfg_ff;
            end else if (hold_ff != '0) begin
               hold_in = hold_ff - 8'd1;
            end
         end
         ST_PK_SUB:  pk_in = pk_ff - rel_step;
         ST_PDB_LOG: begin
            pdb_in = floor_db_ff;
            mag_in = log_res.mag;
            neg_in = log_res.neg;
         end
         ST_PDB_RND: pdb_in = db_val;
         ST_DONE: begin
            if (out_free) begin
               smooth_in[ch_ff] = cur_ff;
               peak_in[ch_ff]   = pk_ff;
               pkdb_in[ch_ff]   = pdb_ff;
               holdc_in[ch_ff]  = hold_ff;
               rsp_valid_in     = 1'b1;
               rsp_ch_in        = ch_ff;
               rsp_ldb_in       = ldb_ff;
               rsp_pdb_in       = pdb_ff;
               rsp_hold_in      = hold_ff != '0;
            end
         end
         default: begin
            mag_in = mag_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lvl_coef_ff  <= LEVEL_COEF_RST;
         pk_coef_ff   <= PEAK_COEF_RST;
         hold_cfg_ff  <= HOLD_RST;
         floor_lvl_ff <= FLOOR_LVL_RST;
         floor_db_ff  <= FLOOR_DB_RST;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            smooth_ff[i] <= '0;
            peak_ff[i]   <= '0;
            pkdb_ff[i]   <= FLOOR_DB_RST;
            holdc_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         lvl_coef_ff  <= lvl_coef_in;
         pk_coef_ff   <= pk_coef_in;
         hold_cfg_ff  <= hold_cfg_in;
         floor_lvl_ff <= floor_lvl_in;
         floor_db_ff  <= floor_db_in;
         rsp_valid_ff <= rsp_valid_in;
         smooth_ff    <= smooth_in;
         peak_ff      <= peak_in;
         pkdb_ff      <= pkdb_in;
         holdc_ff     <= holdc_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      lvl_ff      <= lvl_in;
      cur_ff      <= cur_in;
      pk_ff       <= pk_in;
      hold_ff     <= hold_in;
      ldb_ff      <= ldb_in;
      pdb_ff      <= pdb_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_ldb_ff  <= rsp_ldb_in;
      rsp_pdb_ff  <= rsp_pdb_in;
      rsp_hold_ff <= rsp_hold_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel_out  = rsp_ch_ff;
   assign rsp_level_db     = rsp_ldb_ff;
   assign rsp_peak_db      = rsp_pdb_ff;
   assign rsp_peak_holding = rsp_hold_ff;

endmodule

// ===== rtl/lmb_mul.sv =====
// shared unsigned multiplier with registered product
module lmb_mul (
   input  logic                        clock,
   input  logic [lmb_pkg::MAG_W-1:0]   op_a,
   input  logic [lmb_pkg::K_W-1:0]     op_b,
   output logic [lmb_pkg::PROD_W-1:0]  prod
);
   import lmb_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = PROD_W'(op_a) * PROD_W'(op_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/lmb_log2.sv =====
// log2 magnitude of a Q1.15 gain: leading-one position plus linear mantissa
module lmb_log2 (
   input  logic [lmb_pkg::LVL_W-1:0] gain,
   output lmb_pkg::log_type          res
);
   import lmb_pkg::*;

   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] octaves;
   logic [LVL_W-1:0] norm;
   logic [LVL_W-1:0] frac;

   always_comb begin
      pos = '0;
      for (int i = 0; i < LVL_W; i++) begin
         if (gain[i]) begin
            pos = POS_W'(i);
         end
      end
      octaves = POS_W'(LVL_W - 1) - pos;
      norm    = gain << octaves;
      frac    = {norm[LVL_W-2:0], 1'b0};
      if (octaves == '0) begin
         res.neg = 1'b0;
         res.mag = MAG_W'(frac);
      end else begin
         res.neg = 1'b1;
         res.mag = {octaves, {LVL_W{1'b0}}} - MAG_W'(frac);
      end
   end

endmodule

// ===== rtl/lmb_checker.sv =====
// port-level checker for the level meter ballistics block, with its bind
`include "level_meter_ballistics_macros.svh"

module lmb_port_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic signed [lmb_pkg::DB_W-1:0] rsp_level_db,
   input logic signed [lmb_pkg::DB_W-1:0] rsp_peak_db
);
   import lmb_pkg::*;

   `LMB_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp transaction dropped")
   `LMB_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "req taken while busy")
   `LMB_ASSERT_IMP(a_level_db_max, rsp_valid, rsp_level_db <= 16'sd1541, "level dB too high")
   `LMB_ASSERT_IMP(a_peak_db_max, rsp_valid, rsp_peak_db <= 16'sd1541, "peak dB too high")

endmodule

bind level_meter_ballistics lmb_port_checker u_lmb_checker (.*);
